/* src/fat_erw_pkg.sv */
package fat_erw_pkg;

   localparam int STORE_BYTES = 65536;
   localparam int STORE_AW    = $clog2(STORE_BYTES);
   localparam int ADDR_W      = 45;

   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 28;

   localparam logic [1:0] TT_FAT12 = 2'd0;
   localparam logic [1:0] TT_FAT16 = 2'd1;
   localparam logic [1:0] TT_FAT32 = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BEYOND  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_TYPE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SECTOR_LOG2  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RESERVED     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_SECTS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COPY_COUNT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_INDEX    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VALUE    = 3'd6;

   typedef struct packed {
      logic [1:0]  table_type;
      logic [3:0]  sector_size_log2;
      logic [15:0] reserved_count;
      logic [22:0] table_sectors;
      logic [3:0]  copy_count;
      logic [27:0] max_entry_index;
      logic [27:0] max_entry_value;
   } cfg_type;

   typedef struct packed {
      logic                done;
      logic                beyond;
      logic [STORE_AW-1:0] addr;
      logic [1:0]          last;    // bytes touched minus one
   } addr_res_type;

endpackage

/* src/fat_entry_read_write_top.sv */
// FAT12/16/32 allocation-table entry access over a 64 KiB on-chip byte store
// standing in for the disk sectors. req_tuser is the command (0 read, 1 write);
// each item gives exactly one rsp item with status and read value. After reset
// the store is cleared one byte a cycle, and req_tready stays low until that
// pass ends; csr writes are taken at any time but only while idle are they
// meaningful. One item at a time: the accept, an address pipeline (copy
// multiply, base add, sector shift, range check), then the single-port store
// is read byte by byte (2 or 4 bytes, through its registered read port) and,
// for a write, written back byte by byte, then the result register is loaded;
// a rejected item goes from the range check straight to that load. The result
// register lets the next item start while a result waits.
module fat_entry_read_write_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // copy_index[3:0], entry_index[31:4], write_value[59:32], zero pad
   input  logic [fat_erw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], read_value[29:2], zero pad
   output logic [fat_erw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic [fat_erw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fat_erw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fat_erw_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   cfg_type             cfg_ff;
   addr_res_type        addr_res;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [2:0]          cnt_ff;
   logic [2:0]          cnt_in;
   logic [STORE_AW-1:0] clr_ff;

   logic                req_acc;
   logic                arg_bad;
   logic [3:0]          req_copy;
   logic [27:0]         req_entry;
   logic [27:0]         req_wval;

   logic                is_write_ff;
   logic                entry_odd_ff;
   logic [27:0]         wval_ff;
   logic                arg_bad_ff;
   logic [1:0]          status_ff;

   logic [7:0]          sector_store [STORE_BYTES];
   logic                mem_we;
   logic [STORE_AW-1:0] mem_addr;
   logic [7:0]          mem_wdata;
   logic [7:0]          mem_rdata_ff;
   logic [7:0]          byte_ff [4];
   logic [7:0]          new_byte [4];
   logic [27:0]         read_val;
   logic [1:0]          cap_idx;
   logic                rsp_load;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [27:0]         rsp_value_ff;

   assign req_copy  = req_tdata[3:0];
   assign req_entry = req_tdata[31:4];
   assign req_wval  = req_tdata[59:32];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{table_type:       TT_FAT12,
                     sector_size_log2: 4'd9,
                     reserved_count:   16'd1,
                     table_sectors:    23'd1,
                     copy_count:       4'd2,
                     max_entry_index:  28'd4095,
                     max_entry_value:  28'd4095};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TABLE_TYPE:  cfg_ff.table_type       <= csr_wdata[1:0];
            REG_SECTOR_LOG2: cfg_ff.sector_size_log2 <= csr_wdata[3:0];
            REG_RESERVED:    cfg_ff.reserved_count   <= csr_wdata[15:0];
            REG_TABLE_SECTS: cfg_ff.table_sectors    <= csr_wdata[22:0];
            REG_COPY_COUNT:  cfg_ff.copy_count       <= csr_wdata[3:0];
            REG_MAX_INDEX:   cfg_ff.max_entry_index  <= csr_wdata[27:0];
            REG_MAX_VALUE:   cfg_ff.max_entry_value  <= csr_wdata[27:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign arg_bad = (cfg_ff.table_type > TT_FAT32)
                 || (req_tuser && (req_wval > cfg_ff.max_entry_value))
                 || (req_entry > cfg_ff.max_entry_index)
                 || (req_copy >= cfg_ff.copy_count);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         is_write_ff  <= req_tuser;
         entry_odd_ff <= req_entry[0];
         wval_ff      <= req_wval;
         arg_bad_ff   <= arg_bad;
      end
      if (state_ff == S_ADDR && addr_res.done) begin
         if (arg_bad_ff) begin
            status_ff <= ST_INVALID;
         end else if (addr_res.beyond) begin
            status_ff <= ST_BEYOND;
         end else begin
            status_ff <= ST_OK;
         end
      end
   end

   fat_erw_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .start       (req_acc),
      .cfg         (cfg_ff),
      .copy_index  (req_copy),
      .entry_index (req_entry),
      .res         (addr_res)
   );

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) state_in = S_ADDR;
         end
         S_ADDR: begin
            if (addr_res.done) begin
               cnt_in = 3'd0;
               if (arg_bad_ff || addr_res.beyond) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == {1'b0, addr_res.last} + 3'd1) begin
               cnt_in = 3'd0;
               state_in = is_write_ff ? S_WRITE : S_DONE;
            end
         end
         S_WRITE: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff[1:0] == addr_res.last) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= 3'd0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   // byte store, one port, registered read
   assign mem_we    = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
   assign mem_addr  = (state_ff == S_CLEAR) ? clr_ff
                    : addr_res.addr + {{(STORE_AW-2){1'b0}}, cnt_ff[1:0]};
   assign mem_wdata = (state_ff == S_CLEAR) ? 8'd0 : new_byte[cnt_ff[1:0]];

   always_ff @(posedge clock) begin
      if (mem_we) sector_store[mem_addr] <= mem_wdata;
      mem_rdata_ff <= sector_store[mem_addr];
   end

   assign cap_idx = 2'(cnt_ff - 3'd1);

   always_ff @(posedge clock) begin
      if (state_ff == S_READ && cnt_ff != 3'd0) byte_ff[cap_idx] <= mem_rdata_ff;
   end

   // merge write value into the bytes read
   always_comb begin
      new_byte[0] = wval_ff[7:0];
      new_byte[1] = wval_ff[15:8];
      new_byte[2] = wval_ff[23:16];
      new_byte[3] = {byte_ff[3][7:4], wval_ff[27:24]};
      read_val    = {byte_ff[3][3:0], byte_ff[2], byte_ff[1], byte_ff[0]};
      case (cfg_ff.table_type)
         TT_FAT12: begin
            if (entry_odd_ff) begin
               new_byte[0] = {wval_ff[3:0], byte_ff[0][3:0]};
               new_byte[1] = wval_ff[11:4];
               read_val    = {16'd0, byte_ff[1], byte_ff[0][7:4]};
            end else begin
               new_byte[1] = {byte_ff[1][7:4], wval_ff[11:8]};
               read_val    = {16'd0, byte_ff[1][3:0], byte_ff[0]};
            end
         end
         TT_FAT16: read_val = {12'd0, byte_ff[1], byte_ff[0]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= (status_ff == ST_OK && !is_write_ff) ? read_val : 28'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   a_write_only_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> is_write_ff && status_ff == ST_OK)
      else $error("store written for a rejected or read item");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !arg_bad_ff && !addr_res.beyond)
      else $error("store read for a rejected item");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == 28'd0)
      else $error("error result carries a value");

   a_addr_done_waited: assert property (@(posedge clock) disable iff (reset)
      addr_res.done |-> state_ff == S_ADDR)
      else $error("address pipeline finished outside the address wait");
`endif

endmodule

/* src/fat_erw_addr.sv */
module fat_erw_addr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  fat_erw_pkg::cfg_type       cfg,
   input  logic [3:0]                 copy_index,
   input  logic [27:0]                entry_index,
   output fat_erw_pkg::addr_res_type  res
);
   import fat_erw_pkg::*;

   logic [3:0]          vld_ff;
   logic [26:0]         prod_ff;
   logic [29:0]         off1_ff;
   logic [29:0]         off2_ff;
   logic [29:0]         off12;
   logic [1:0]          last1_ff;
   logic [1:0]          last2_ff;
   logic [1:0]          last3_ff;
   logic [1:0]          last4_ff;
   logic [27:0]         sec_ff;
   logic [ADDR_W-1:0]   full_ff;
   logic [ADDR_W-1:0]   end_addr;
   logic                beyond_ff;
   logic [STORE_AW-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   // FAT12 offset is entry*1.5, rounded down
   assign off12 = 30'({1'b0, entry_index} + {2'b00, entry_index[27:1]});

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {23'd0, copy_index} * {4'd0, cfg.table_sectors};
         case (cfg.table_type)
            TT_FAT12: begin
               off1_ff  <= off12;
               last1_ff <= 2'd1;
            end
            TT_FAT16: begin
               off1_ff  <= {1'b0, entry_index, 1'b0};
               last1_ff <= 2'd1;
            end
            default: begin
               off1_ff  <= {entry_index, 2'b00};
               last1_ff <= 2'd3;
            end
         endcase
      end
      if (vld_ff[0]) begin
         sec_ff   <= {12'd0, cfg.reserved_count} + {1'b0, prod_ff};
         off2_ff  <= off1_ff;
         last2_ff <= last1_ff;
      end
      if (vld_ff[1]) begin
         full_ff  <= ({17'd0, sec_ff} << cfg.sector_size_log2) + {15'd0, off2_ff};
         last3_ff <= last2_ff;
      end
      if (vld_ff[2]) begin
         beyond_ff <= |end_addr[ADDR_W-1:STORE_AW];
         addr_ff   <= full_ff[STORE_AW-1:0];
         last4_ff  <= last3_ff;
      end
   end

   assign end_addr = full_ff + {{(ADDR_W-2){1'b0}}, last3_ff};

   assign res.done   = vld_ff[3];
   assign res.beyond = beyond_ff;
   assign res.addr   = addr_ff;
   assign res.last   = last4_ff;

endmodule
